@@ src/icol_pkg.sv @@
// shared constants, stage types and gradient tables for the iteration colorizer
package icol_pkg;

  localparam int STOP_COUNT = 12;
  localparam int SEG_W      = 4;
  localparam int T_W        = 16;
  localparam int F_W        = 17;
  localparam int SPAN_W     = 13;
  localparam int SQ_STAGES  = 16;
  localparam int DIV_STAGES = 16;
  localparam logic [15:0] LIMIT_RESET = 16'd255;

  typedef struct packed {
    logic        v;
    logic        blk;
    logic [7:0]  num;
    logic [7:0]  den;
    logic [15:0] x;
    logic [23:0] xd;
    logic [39:0] sq;
  } sq_stage_t;

  typedef struct packed {
    logic              v;
    logic              blk;
    logic [SEG_W-1:0]  seg;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] rem;
    logic [F_W-1:0]    q;
  } div_stage_t;

  // stop positions in q0.16, the last one is exactly 1.0
  function automatic logic [16:0] stop_pos(input logic [SEG_W-1:0] idx);
    logic [16:0] p;
    case (idx)
      4'd0:    p = 17'd0;
      4'd1:    p = 17'd1311;
      4'd2:    p = 17'd3277;
      4'd3:    p = 17'd6554;
      4'd4:    p = 17'd11796;
      4'd5:    p = 17'd18350;
      4'd6:    p = 17'd26214;
      4'd7:    p = 17'd34079;
      4'd8:    p = 17'd41943;
      4'd9:    p = 17'd49807;
      4'd10:   p = 17'd57672;
      4'd11:   p = 17'd65536;
      default: p = 17'd65536;
    endcase
    return p;
  endfunction

  // channel 0 red, 1 green, 2 blue
  function automatic logic [7:0] stop_rgb(input logic [SEG_W-1:0] idx, input logic [1:0] ch);
    logic [23:0] c;
    case (idx)
      4'd0:    c = {8'd0,   8'd0,   8'd0};
      4'd1:    c = {8'd26,  8'd7,   8'd25};
      4'd2:    c = {8'd120, 8'd30,  8'd15};
      4'd3:    c = {8'd200, 8'd80,  8'd30};
      4'd4:    c = {8'd230, 8'd160, 8'd20};
      4'd5:    c = {8'd180, 8'd220, 8'd30};
      4'd6:    c = {8'd80,  8'd235, 8'd120};
      4'd7:    c = {8'd60,  8'd240, 8'd245};
      4'd8:    c = {8'd35,  8'd180, 8'd255};
      4'd9:    c = {8'd60,  8'd100, 8'd255};
      4'd10:   c = {8'd170, 8'd70,  8'd255};
      4'd11:   c = {8'd255, 8'd120, 8'd210};
      default: c = 24'd0;
    endcase
    case (ch)
      2'd0:    return c[7:0];
      2'd1:    return c[15:8];
      2'd2:    return c[23:16];
      default: return 8'd0;
    endcase
  endfunction

endpackage

@@ src/iteration_palette_colorizer_top.sv @@
// top level of the iteration count to rgb gradient colorizer
//  channel | dir | ports                      | content
//  in      | in  | in_tvalid/in_tready/in_tdata   | iteration count, 8 bits
//  out     | out | out_tvalid/out_tready/out_tdata | red, green, blue, 8 bits each
//  cfg     | in  | cfg_we/cfg_wdata            | iteration limit, 16 bits
// one beat per cycle while out_tready does not stall the pipe; 16 root stages, segment
// select, 16 divide stages, 2 blend stages
// reset is synchronous active low, empties the pipe and sets the limit to 255
// a stall on out_tready freezes the whole pipe and drops in_tready only while
// the output register holds an untaken beat
module iteration_palette_colorizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] iteration_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]          limit_r;
  logic [7:0]           lim;
  logic                 en;
  icol_pkg::sq_stage_t  head;
  icol_pkg::sq_stage_t  sq_tail;
  icol_pkg::div_stage_t div_tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= icol_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (limit_r == 16'd0) begin
      lim = 8'd1;
    end else if (limit_r > 16'd255) begin
      lim = 8'd255;
    end else begin
      lim = limit_r[7:0];
    end
  end

  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  always_comb begin
    head.v   = in_tvalid;
    head.blk = in_tdata >= lim;
    head.num = in_tdata;
    head.den = lim;
    head.x   = '0;
    head.xd  = '0;
    head.sq  = '0;
  end

  icol_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .head (head),
    .tail (sq_tail)
  );

  icol_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (sq_tail.v),
    .in_blk(sq_tail.blk),
    .in_t  (sq_tail.x),
    .tail  (div_tail)
  );

  icol_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .head   (div_tail),
    .out_v  (out_tvalid),
    .out_rgb(out_tdata)
  );

endmodule

@@ src/icol_sqrt.sv @@
// pipelined bit-by-bit square root of count/limit in q0.16, one bit per stage
module icol_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  icol_pkg::sq_stage_t head,
  output icol_pkg::sq_stage_t tail
);

  icol_pkg::sq_stage_t sq_r [icol_pkg::SQ_STAGES];

  for (genvar s = 0; s < icol_pkg::SQ_STAGES; s++) begin : g_stage
    localparam int B = icol_pkg::SQ_STAGES - 1 - s;
    icol_pkg::sq_stage_t cur;
    icol_pkg::sq_stage_t nxt;
    logic [39:0] cand_sq;
    logic [39:0] target;

    if (s == 0) begin : g_first
      assign cur = head;
    end else begin : g_rest
      assign cur = sq_r[s-1];
    end

    // (x + 2^b)^2 * den = sq + x*den*2^(b+1) + den*2^(2b)
    assign cand_sq = cur.sq + ({16'd0, cur.xd} << (B + 1)) + ({32'd0, cur.den} << (2 * B));
    assign target  = {cur.num, 32'd0};

    always_comb begin
      nxt = cur;
      if (cand_sq <= target) begin
        nxt.sq = cand_sq;
        nxt.x  = cur.x | (16'd1 << B);
        nxt.xd = cur.xd + ({16'd0, cur.den} << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[s].v <= 1'b0;
      end else if (en) begin
        sq_r[s].v <= nxt.v;
      end
      if (en) begin
        sq_r[s].blk <= nxt.blk;
        sq_r[s].num <= nxt.num;
        sq_r[s].den <= nxt.den;
        sq_r[s].x   <= nxt.x;
        sq_r[s].xd  <= nxt.xd;
        sq_r[s].sq  <= nxt.sq;
      end
    end
  end

  assign tail = sq_r[icol_pkg::SQ_STAGES-1];

endmodule

@@ src/icol_div.sv @@
// segment select and pipelined restoring division for the local fraction
module icol_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic                 in_blk,
  input  logic [15:0]          in_t,
  output icol_pkg::div_stage_t tail
);

  icol_pkg::div_stage_t seg_r;
  icol_pkg::div_stage_t seg_nxt;
  icol_pkg::div_stage_t dv_r [icol_pkg::DIV_STAGES];

  always_comb begin
    logic [icol_pkg::SEG_W-1:0] seg;
    logic [16:0] left;
    logic [16:0] right;
    logic [16:0] d;
    logic [16:0] w;
    seg = 4'd10;
    for (int c = 10; c >= 0; c--) begin
      if ({1'b0, in_t} <= icol_pkg::stop_pos(4'(c + 1))) begin
        seg = 4'(c);
      end
    end
    left  = icol_pkg::stop_pos(seg);
    right = icol_pkg::stop_pos(seg + 4'd1);
    d     = {1'b0, in_t} - left;
    w     = right - left;
    seg_nxt.v    = in_v;
    seg_nxt.blk  = in_blk;
    seg_nxt.seg  = seg;
    seg_nxt.span = w[icol_pkg::SPAN_W-1:0];
    // t never exceeds the right stop, so the integer quotient bit is just d == span
    if (d == w) begin
      seg_nxt.rem = '0;
      seg_nxt.q   = 17'd1;
    end else begin
      seg_nxt.rem = d[icol_pkg::SPAN_W-1:0];
      seg_nxt.q   = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r.v <= 1'b0;
    end else if (en) begin
      seg_r.v <= seg_nxt.v;
    end
    if (en) begin
      seg_r.blk  <= seg_nxt.blk;
      seg_r.seg  <= seg_nxt.seg;
      seg_r.span <= seg_nxt.span;
      seg_r.rem  <= seg_nxt.rem;
      seg_r.q    <= seg_nxt.q;
    end
  end

  for (genvar s = 0; s < icol_pkg::DIV_STAGES; s++) begin : g_stage
    icol_pkg::div_stage_t cur;
    icol_pkg::div_stage_t nxt;
    logic [icol_pkg::SPAN_W:0] r2;

    if (s == 0) begin : g_first
      assign cur = seg_r;
    end else begin : g_rest
      assign cur = dv_r[s-1];
    end

    assign r2 = {cur.rem, 1'b0};

    always_comb begin
      nxt = cur;
      if (r2 >= {1'b0, cur.span}) begin
        nxt.rem = icol_pkg::SPAN_W'(r2 - {1'b0, cur.span});
        nxt.q   = {cur.q[icol_pkg::F_W-2:0], 1'b1};
      end else begin
        nxt.rem = r2[icol_pkg::SPAN_W-1:0];
        nxt.q   = {cur.q[icol_pkg::F_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s].v <= 1'b0;
      end else if (en) begin
        dv_r[s].v <= nxt.v;
      end
      if (en) begin
        dv_r[s].blk  <= nxt.blk;
        dv_r[s].seg  <= nxt.seg;
        dv_r[s].span <= nxt.span;
        dv_r[s].rem  <= nxt.rem;
        dv_r[s].q    <= nxt.q;
      end
    end
  end

  assign tail = dv_r[icol_pkg::DIV_STAGES-1];

endmodule

@@ src/icol_blend.sv @@
// two-stage linear blend between the segment's stop colors, round half up
module icol_blend (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  icol_pkg::div_stage_t head,
  output logic                 out_v,
  output logic [23:0]          out_rgb
);

  logic               mul_v_r;
  logic               mul_blk_r;
  logic [7:0]         base_r [3];
  logic signed [26:0] prod_r [3];
  logic               out_v_r;
  logic [7:0]         chan_r [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    logic [7:0]         a;
    logic [7:0]         b;
    logic signed [8:0]  diff;
    logic signed [26:0] prod_nxt;
    logic signed [26:0] sum;
    logic [7:0]         chan_nxt;

    assign a        = icol_pkg::stop_rgb(head.seg, 2'(ch));
    assign b        = icol_pkg::stop_rgb(head.seg + 4'd1, 2'(ch));
    assign diff     = $signed({1'b0, b}) - $signed({1'b0, a});
    assign prod_nxt = 27'(diff * $signed({1'b0, head.q}));
    // a*(1-f) + b*f == a + (b-a)*f, total stays non-negative
    assign sum      = $signed({3'd0, base_r[ch], 16'd0}) + prod_r[ch] + 27'sd32768;
    assign chan_nxt = mul_blk_r ? 8'd0 : sum[23:16];

    always_ff @(posedge clk) begin
      if (en) begin
        base_r[ch] <= a;
        prod_r[ch] <= prod_nxt;
        chan_r[ch] <= chan_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r <= head.v;
      out_v_r <= mul_v_r;
    end
    if (en) begin
      mul_blk_r <= head.blk;
    end
  end

  assign out_v   = out_v_r;
  assign out_rgb = {chan_r[2], chan_r[1], chan_r[0]};

endmodule

@@ src/icol_checker.sv @@
// port-level checks for the colorizer, bound to the top level
module icol_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a held beat stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // empty output never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // the pipe is empty right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // input only stalls behind a stalled output beat
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind iteration_palette_colorizer_top icol_checker u_icol_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

@@ bench/tb.sv @@
// testbench for the iteration palette colorizer: directed and random counts, checked per beat
`timescale 1ns / 100ps

module tb;

  localparam int LAT_WAIT = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] iteration_count
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [7:0] red, [15:8] green, [23:16] blue
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  iteration_palette_colorizer_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [7:0]  count_queue[$];
  pixel_t      pixel_queue[$];
  logic [15:0] limit_reg = 16'd255;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          mismatches = 0;
  int          pixels_seen = 0;
  int          black_seen = 0;

  int unsigned stop_q[12] = '{0, 1311, 3277, 6554, 11796, 18350,
                              26214, 34079, 41943, 49807, 57672, 65536};
  logic [7:0]  stop_red[12]   = '{0, 25, 15, 30, 20, 30, 120, 245, 255, 255, 255, 210};
  logic [7:0]  stop_green[12] = '{0, 7, 30, 80, 160, 220, 235, 240, 180, 100, 70, 120};
  logic [7:0]  stop_blue[12]  = '{0, 26, 120, 200, 230, 180, 80, 60, 35, 60, 170, 255};

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input longint unsigned f);
    longint unsigned s;
    s = a * (65536 - f) + b * f + 32768;
    return s[23:16];
  endfunction

  function automatic pixel_t colorize(input logic [7:0] count, input logic [15:0] lim_raw);
    longint unsigned lim, x, cand, f;
    int seg;
    pixel_t p;
    lim = (lim_raw > 255) ? 255 : (lim_raw == 0 ? 1 : lim_raw);
    p = '0;
    if (count >= lim) return p;
    x = 0;
    for (int b = 15; b >= 0; b--) begin
      cand = x | (64'd1 << b);
      if (cand * cand * lim <= (longint'(count) << 32)) x = cand;
    end
    seg = 10;
    for (int c = 0; c < 11; c++) begin
      if (x <= stop_q[c+1]) begin
        seg = c;
        break;
      end
    end
    if (x <= stop_q[seg]) f = 0;
    else begin
      f = ((x - stop_q[seg]) << 16) / (stop_q[seg+1] - stop_q[seg]);
      if (f > 65536) f = 65536;
    end
    p.red   = mix(stop_red[seg], stop_red[seg+1], f);
    p.green = mix(stop_green[seg], stop_green[seg+1], f);
    p.blue  = mix(stop_blue[seg], stop_blue[seg+1], f);
    return p;
  endfunction

  // driver: prediction is made when the beat is taken, with the limit then in force
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pixel_queue.push_back(colorize(in_tdata, limit_reg));
        void'(count_queue.pop_front());
      end
      if ((!in_tvalid || in_tready) && count_queue.size() > 0
          && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= count_queue[0];
      end else if (!in_tvalid || in_tready) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      pixels_seen <= pixels_seen + 1;
      if (got == '0) black_seen <= black_seen + 1;
      if (pixel_queue.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = pixel_queue.pop_front();
        if (want.red !== got.red || want.green !== got.green || want.blue !== got.blue) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("pixel mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  task automatic drain();
    while (count_queue.size() != 0 || in_tvalid || pixel_queue.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    limit_reg <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] lim_list[8] = '{16'd255, 16'd0, 16'd1, 16'd65535, 16'd100, 16'd256,
                                 16'd37, 16'd200};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, stops and limit edges at the reset limit
    foreach (stop_q[i])
      count_queue.push_back(8'((64'(stop_q[i]) * stop_q[i] * 255) >> 32));
    count_queue.push_back(8'd0);
    count_queue.push_back(8'd1);
    count_queue.push_back(8'd254);
    count_queue.push_back(8'd255);
    count_queue.push_back(8'h55);
    count_queue.push_back(8'hAA);
    count_queue.push_back(8'd128);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      set_limit(lim_list[ph]);
      if (ph < 3) begin
        send_idle_pct = 19; recv_idle_pct = 78;
      end else if (ph < 6) begin
        send_idle_pct = 78; recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (ph == 6) hold_cycles = 200;
      for (int k = 0; k < 105; k++) begin
        if ($urandom_range(3) == 0) count_queue.push_back($urandom_range(255));
        else count_queue.push_back($urandom_range(lim_list[ph] > 255 ? 255 : lim_list[ph]));
      end
      drain();
    end
    $display("tb: %0d pixels checked, %0d black, over 9 limit settings", pixels_seen, black_seen);
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
